### design/gjmi_pkg.sv
// Shared types and constants for the Gauss-Jordan matrix inverter.
// No dependencies; imported by gjmi_ram and gauss_jordan_matrix_inverse.
package gjmi_pkg;

   localparam int DEF_MAX_ORDER     = 8;
   localparam int DEF_FRACTION_BITS = 16;
   localparam int VALUE_W           = 32;
   localparam int CSR_W             = 4;
   localparam logic [CSR_W-1:0] MATRIX_SIZE_RESET = 4'd8;

   typedef struct packed {
      logic signed [VALUE_W-1:0] element_value;
      logic                      last_element;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] inverse_value;
      logic                      singular;
      logic                      last_result;
   } rsp_word_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_FILL,
      ST_DRAIN,
      ST_IDENT,
      ST_PIV_RD,
      ST_PIV_CHK,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_SWP_RDA,
      ST_SWP_RDB,
      ST_SWP_WRA,
      ST_SWP_WRB,
      ST_DIV_RD,
      ST_DIV_LD,
      ST_DIV_RUN,
      ST_DIV_WR,
      ST_EL_FRD,
      ST_EL_FCAP,
      ST_EL_YRD,
      ST_EL_XRD,
      ST_EL_MUL,
      ST_EL_SUB,
      ST_EL_WR,
      ST_OUT_RD,
      ST_OUT_CAP,
      ST_SING,
      ST_OUT_HOLD
   } state_type;

endpackage

### design/gjmi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Default width and depth come from gjmi_pkg.
module gjmi_ram import gjmi_pkg::*; #(
   parameter int WIDTH = VALUE_W,
   parameter int DEPTH = 2 * DEF_MAX_ORDER * DEF_MAX_ORDER
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/gauss_jordan_matrix_inverse.sv
// Gauss-Jordan matrix inverter, signed fixed point, top level.
// Depends on gjmi_pkg and gjmi_ram.
//
// Usage:
//   csr_*  : write channel for matrix_size (order n, 0 acts as 1, clamped to
//            MAX_ORDER). Always ready; write only while the block is idle.
//   req_*  : matrix elements in row-major order, one word per cycle while
//            loading. last_element, or the n*n-th element, starts the run;
//            missing elements count as zero.
//   rsp_*  : n*n inverse words in row-major order, last_result on the final
//            one, or a single word flagged singular.
// Sequence: after the final element the store is zero-padded for any missing
//   elements and the identity half written. Every pivot row then runs 2n
//   divides on the shared restoring divider, and every other row 2n
//   multiply-subtract steps.
// req_ready is low from the start of a run until the last result word is
//   taken; a stalled receiver simply holds the word. Reset is synchronous and
//   returns to loading with an empty element count and matrix_size 8.
module gauss_jordan_matrix_inverse import gjmi_pkg::*; #(
   parameter int MAX_ORDER     = DEF_MAX_ORDER,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [CSR_W-1:0] csr_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   localparam int AUG_COLS = 2 * MAX_ORDER;
   localparam int DEPTH    = MAX_ORDER * AUG_COLS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int ORD_W    = $clog2(MAX_ORDER + 1);
   localparam int CNT_W    = $clog2(AUG_COLS + 1);
   localparam int LC_W     = $clog2(MAX_ORDER * MAX_ORDER + 1);
   localparam int RSH      = LC_W + ORD_W + 1;
   localparam int RCP_W    = RSH + 1;
   localparam int PQ_W     = LC_W + RCP_W;
   localparam int NUM_W    = VALUE_W + FRACTION_BITS;
   localparam int DC_W     = $clog2(NUM_W + 1);
   localparam logic [VALUE_W-1:0] ONE     = VALUE_W'(64'd1 << FRACTION_BITS);
   localparam logic [VALUE_W-1:0] SAT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] SAT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   function automatic logic [ADDR_W-1:0] aug_addr(input logic [CNT_W-1:0] row,
                                                  input logic [CNT_W-1:0] col);
      aug_addr = ADDR_W'(int'(row) * AUG_COLS + int'(col));
   endfunction

   function automatic logic [ORD_W-1:0] clamp_order(input logic [CSR_W-1:0] v);
      if (v == '0) begin
         clamp_order = ORD_W'(1);
      end else if (int'(v) > MAX_ORDER) begin
         clamp_order = ORD_W'(MAX_ORDER);
      end else begin
         clamp_order = ORD_W'(v);
      end
   endfunction

   // reciprocal table for row = count / n by multiply and shift
   logic [RCP_W-1:0] recip_tab [MAX_ORDER+1];
   assign recip_tab[0] = '0;
   for (genvar g = 1; g <= MAX_ORDER; g++) begin : g_recip
      localparam int unsigned RCP = ((1 << RSH) + g - 1) / g;
      assign recip_tab[g] = RCP_W'(RCP);
   end

   state_type state_ff, state_in;
   logic [ORD_W-1:0] n_ff, n_in;
   logic [LC_W-1:0]  total_ff, total_in;
   logic [LC_W-1:0]  lc_ff, lc_in;
   logic [LC_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0] i_ff, i_in, k_ff, k_in, j_ff, j_in;
   logic [VALUE_W-1:0] tmp_ff, tmp_in, piv_ff, piv_in;
   logic signed [VALUE_W-1:0] f_ff, f_in, y_ff, y_in, x_ff, x_in;
   logic signed [63:0] prod_ff, prod_in, tq_ff, tq_in;
   logic [NUM_W-1:0] div_quo_ff, div_quo_in;
   logic [VALUE_W:0] div_rem_ff, div_rem_in;
   logic [VALUE_W-1:0] div_den_ff, div_den_in;
   logic div_neg_ff, div_neg_in;
   logic [DC_W-1:0] div_cnt_ff, div_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;

   // load write stage
   logic pa_valid_ff, pa_valid_in;
   logic [LC_W-1:0] pa_cnt_ff, pa_cnt_in;
   logic [ORD_W-1:0] pa_n_ff;
   logic [PQ_W-1:0] pa_qprod_ff, pa_qprod_in;
   logic [VALUE_W-1:0] pa_val_ff, pa_val_in;
   logic [ORD_W-1:0] pb_q;
   logic [LC_W-1:0]  pb_col;
   logic [ADDR_W-1:0] pb_addr;

   logic seq_we;
   logic [ADDR_W-1:0] seq_waddr, mem_raddr;
   logic [VALUE_W-1:0] seq_wdata, mem_rdata;

   logic [CNT_W-1:0] n_c, n_last, w_last;
   logic [VALUE_W:0] rem_sh;
   logic [VALUE_W-1:0] div_res, x_abs;
   logic signed [64:0] diff;
   logic [VALUE_W-1:0] elim_res;

   assign n_c    = CNT_W'(n_ff);
   assign n_last = n_c - CNT_W'(1);
   assign w_last = CNT_W'({n_ff, 1'b0}) - CNT_W'(1);

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign pb_q    = ORD_W'(pa_qprod_ff >> RSH);
   assign pb_col  = LC_W'(pa_cnt_ff - LC_W'(LC_W'(pb_q) * LC_W'(pa_n_ff)));
   assign pb_addr = ADDR_W'(int'(pb_q) * AUG_COLS + int'(pb_col));

   gjmi_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (pa_valid_ff | seq_we),
      .waddr(pa_valid_ff ? pb_addr : seq_waddr),
      .wdata(pa_valid_ff ? pa_val_ff : seq_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   // divider step and result saturation
   assign rem_sh = {div_rem_ff[VALUE_W-1:0], div_quo_ff[NUM_W-1]};
   assign x_abs  = mem_rdata[VALUE_W-1] ? (~mem_rdata + VALUE_W'(1)) : mem_rdata;
   always_comb begin
      if (!div_neg_ff) begin
         div_res = (|div_quo_ff[NUM_W-1:VALUE_W-1]) ? SAT_MAX : div_quo_ff[VALUE_W-1:0];
      end else if ((|div_quo_ff[NUM_W-1:VALUE_W]) ||
                   (div_quo_ff[VALUE_W-1] && (|div_quo_ff[VALUE_W-2:0]))) begin
         div_res = SAT_MIN;
      end else begin
         div_res = ~div_quo_ff[VALUE_W-1:0] + VALUE_W'(1);
      end
   end

   // x - f*y, saturated once
   assign diff = {{33{x_ff[VALUE_W-1]}}, x_ff} - {tq_ff[63], tq_ff};
   always_comb begin
      if (diff[64] && !(&diff[63:VALUE_W-1])) begin
         elim_res = SAT_MIN;
      end else if (!diff[64] && (|diff[63:VALUE_W-1])) begin
         elim_res = SAT_MAX;
      end else begin
         elim_res = diff[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         n_ff         <= clamp_order(MATRIX_SIZE_RESET);
         total_ff     <= LC_W'(LC_W'(clamp_order(MATRIX_SIZE_RESET)) *
                               LC_W'(clamp_order(MATRIX_SIZE_RESET)));
         lc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         pa_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         total_ff     <= total_in;
         lc_ff        <= lc_in;
         rsp_valid_ff <= rsp_valid_in;
         pa_valid_ff  <= pa_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff     <= fill_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      tmp_ff      <= tmp_in;
      piv_ff      <= piv_in;
      f_ff        <= f_in;
      y_ff        <= y_in;
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      tq_ff       <= tq_in;
      div_quo_ff  <= div_quo_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      div_neg_ff  <= div_neg_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_data_ff <= rsp_data_in;
      pa_cnt_ff   <= pa_cnt_in;
      pa_n_ff     <= n_ff;
      pa_qprod_ff <= pa_qprod_in;
      pa_val_ff   <= pa_val_in;
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      total_in     = total_ff;
      lc_in        = lc_ff;
      fill_in      = fill_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      tmp_in       = tmp_ff;
      piv_in       = piv_ff;
      f_in         = f_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      prod_in      = prod_ff;
      tq_in        = tq_ff;
      div_quo_in   = div_quo_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_neg_in   = div_neg_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pa_valid_in  = 1'b0;
      pa_cnt_in    = lc_ff;
      pa_val_in    = req_data.element_value;
      seq_we       = 1'b0;
      seq_waddr    = '0;
      seq_wdata    = '0;
      mem_raddr    = '0;

      if (csr_valid) begin
         n_in     = clamp_order(csr_data);
         total_in = LC_W'(LC_W'(n_in) * LC_W'(n_in));
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (lc_ff < total_ff) begin
                  pa_valid_in = 1'b1;
                  lc_in       = lc_ff + LC_W'(1);
                  if (req_data.last_element || (lc_in >= total_ff)) begin
                     fill_in  = lc_in;
                     lc_in    = '0;
                     state_in = ST_FILL;
                  end
               end else begin
                  // surplus word: dropped, run starts
                  fill_in  = lc_ff;
                  lc_in    = '0;
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            if (fill_ff < total_ff) begin
               pa_valid_in = 1'b1;
               pa_cnt_in   = fill_ff;
               pa_val_in   = '0;
               fill_in     = fill_ff + LC_W'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pa_valid_ff) begin
               i_in     = '0;
               j_in     = '0;
               state_in = ST_IDENT;
            end
         end
         ST_IDENT: begin
            seq_we    = 1'b1;
            seq_waddr = aug_addr(i_ff, n_c + j_ff);
            seq_wdata = (i_ff == j_ff) ? ONE : '0;
            if (j_ff == n_last) begin
               j_in = '0;
               if (i_ff == n_last) begin
                  i_in     = '0;
                  state_in = ST_PIV_RD;
               end else begin
                  i_in = i_ff + CNT_W'(1);
               end
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         ST_PIV_RD: begin
            mem_raddr = aug_addr(i_ff, i_ff);
            state_in  = ST_PIV_CHK;
         end
         ST_PIV_CHK: begin
            if (mem_rdata != '0) begin
               piv_in   = mem_rdata;
               j_in     = '0;
               state_in = ST_DIV_RD;
            end else begin
               k_in     = i_ff + CNT_W'(1);
               state_in = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            if (k_ff >= n_c) begin
               state_in = ST_SING;
            end else begin
               mem_raddr = aug_addr(k_ff, i_ff);
               state_in  = ST_SRCH_CHK;
            end
         end
         ST_SRCH_CHK: begin
            if (mem_rdata != '0) begin
               j_in     = '0;
               state_in = ST_SWP_RDA;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               state_in = ST_SRCH_RD;
            end
         end
         ST_SWP_RDA: begin
            mem_raddr = aug_addr(i_ff, j_ff);
            state_in  = ST_SWP_RDB;
         end
         ST_SWP_RDB: begin
            tmp_in    = mem_rdata;
            mem_raddr = aug_addr(k_ff, j_ff);
            state_in  = ST_SWP_WRA;
         end
         ST_SWP_WRA: begin
            seq_we    = 1'b1;
            seq_waddr = aug_addr(i_ff, j_ff);
            seq_wdata = mem_rdata;
            state_in  = ST_SWP_WRB;
         end
         ST_SWP_WRB: begin
            seq_we    = 1'b1;
            seq_waddr = aug_addr(k_ff, j_ff);
            seq_wdata = tmp_ff;
            if (j_ff == w_last) begin
               state_in = ST_PIV_RD;
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_SWP_RDA;
            end
         end
         ST_DIV_RD: begin
            mem_raddr = aug_addr(i_ff, j_ff);
            state_in  = ST_DIV_LD;
         end
         ST_DIV_LD: begin
            div_neg_in = mem_rdata[VALUE_W-1] ^ piv_ff[VALUE_W-1];
            div_quo_in = NUM_W'(x_abs) << FRACTION_BITS;
            div_den_in = piv_ff[VALUE_W-1] ? (~piv_ff + VALUE_W'(1)) : piv_ff;
            div_rem_in = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            // restoring division, one quotient bit per cycle
            if (rem_sh >= {1'b0, div_den_ff}) begin
               div_rem_in = rem_sh - {1'b0, div_den_ff};
               div_quo_in = {div_quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               div_rem_in = rem_sh;
               div_quo_in = {div_quo_ff[NUM_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + DC_W'(1);
            if (div_cnt_ff == DC_W'(NUM_W - 1)) begin
               state_in = ST_DIV_WR;
            end
         end
         ST_DIV_WR: begin
            seq_we    = 1'b1;
            seq_waddr = aug_addr(i_ff, j_ff);
            seq_wdata = div_res;
            if (j_ff == w_last) begin
               k_in     = '0;
               state_in = ST_EL_FRD;
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_DIV_RD;
            end
         end
         ST_EL_FRD: begin
            if (k_ff >= n_c) begin
               if (i_ff == n_last) begin
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_OUT_RD;
               end else begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = ST_PIV_RD;
               end
            end else if (k_ff == i_ff) begin
               k_in = k_ff + CNT_W'(1);
            end else begin
               mem_raddr = aug_addr(k_ff, i_ff);
               state_in  = ST_EL_FCAP;
            end
         end
         ST_EL_FCAP: begin
            f_in     = mem_rdata;
            j_in     = '0;
            state_in = ST_EL_YRD;
         end
         ST_EL_YRD: begin
            mem_raddr = aug_addr(i_ff, j_ff);
            state_in  = ST_EL_XRD;
         end
         ST_EL_XRD: begin
            y_in      = mem_rdata;
            mem_raddr = aug_addr(k_ff, j_ff);
            state_in  = ST_EL_MUL;
         end
         ST_EL_MUL: begin
            prod_in  = 64'(f_ff) * 64'(y_ff);
            x_in     = mem_rdata;
            state_in = ST_EL_SUB;
         end
         ST_EL_SUB: begin
            // scale down, truncating toward zero
            tq_in = prod_ff >>> FRACTION_BITS;
            if (prod_ff[63] && (prod_ff[FRACTION_BITS-1:0] != '0)) begin
               tq_in = tq_in + 64'sd1;
            end
            state_in = ST_EL_WR;
         end
         ST_EL_WR: begin
            seq_we    = 1'b1;
            seq_waddr = aug_addr(k_ff, j_ff);
            seq_wdata = elim_res;
            if (j_ff == w_last) begin
               k_in     = k_ff + CNT_W'(1);
               state_in = ST_EL_FRD;
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_EL_YRD;
            end
         end
         ST_OUT_RD: begin
            mem_raddr = aug_addr(i_ff, n_c + j_ff);
            state_in  = ST_OUT_CAP;
         end
         ST_OUT_CAP: begin
            rsp_data_in.inverse_value = mem_rdata;
            rsp_data_in.singular      = 1'b0;
            rsp_data_in.last_result   = (i_ff == n_last) && (j_ff == n_last);
            rsp_valid_in              = 1'b1;
            state_in                  = ST_OUT_HOLD;
         end
         ST_SING: begin
            rsp_data_in.inverse_value = '0;
            rsp_data_in.singular      = 1'b1;
            rsp_data_in.last_result   = 1'b1;
            rsp_valid_in              = 1'b1;
            state_in                  = ST_OUT_HOLD;
         end
         ST_OUT_HOLD: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_data_ff.last_result) begin
                  state_in = ST_LOAD;
               end else begin
                  if (j_ff == n_last) begin
                     j_in = '0;
                     i_in = i_ff + CNT_W'(1);
                  end else begin
                     j_in = j_ff + CNT_W'(1);
                  end
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      pa_qprod_in = PQ_W'(pa_cnt_in) * PQ_W'(recip_tab[n_ff]);
   end

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result word is pending");

   a_singular_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.singular) |->
         (rsp_data.last_result && (rsp_data.inverse_value == '0)))
      else $error("singular word not final or not zero");

   a_load_writes: assert property (@(posedge clock) disable iff (reset)
      pa_valid_ff |-> ((state_ff == ST_LOAD) || (state_ff == ST_FILL) ||
                       (state_ff == ST_DRAIN)))
      else $error("load write during elimination");
`endif

endmodule

### bench/tb_gauss_jordan_matrix_inverse.sv
// Testbench for gauss_jordan_matrix_inverse: drives matrices, predicts inverses in Q16.16.
// Depends on gjmi_pkg and the gauss_jordan_matrix_inverse RTL.
module tb_gauss_jordan_matrix_inverse;
   import gjmi_pkg::*;

   localparam int ORD = DEF_MAX_ORDER;
   localparam int FB  = DEF_FRACTION_BITS;
   localparam int ONE = 1 << FB;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   gauss_jordan_matrix_inverse uut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // predictor state
   int aug [0:ORD-1][0:2*ORD-1];
   int load_cnt = 0;
   logic [CSR_W-1:0] order_reg = MATRIX_SIZE_RESET;

   req_word_type element_q[$];
   rsp_word_type inverse_q[$];
   int errors = 0;
   int items = 0;

   initial forever #5 clock = ~clock;

   function automatic int eff_order();
      if (order_reg == 0) return 1;
      if (order_reg > ORD) return ORD;
      return int'(order_reg);
   endfunction

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic int q_div(int x, int p);
      longint num;
      num = longint'(x) * longint'(ONE);
      return sat32(num / longint'(p));
   endfunction

   function automatic int q_elim(int x, int f, int y);
      longint prod;
      prod = (longint'(f) * longint'(y)) / longint'(ONE);
      return sat32(longint'(x) - prod);
   endfunction

   function automatic bit run_inverse(int n);
      int t, p, f;
      for (int i = 0; i < n; i++)
         for (int j = n; j < 2*n; j++) aug[i][j] = (i == j - n) ? ONE : 0;
      for (int i = 0; i < n; i++) begin
         if (aug[i][i] == 0) begin
            for (int k = i + 1; k < n; k++) begin
               if (aug[k][i] != 0) begin
                  // whole stored row moves, unused columns too
                  for (int j = 0; j < 2*ORD; j++) begin
                     t = aug[i][j]; aug[i][j] = aug[k][j]; aug[k][j] = t;
                  end
                  break;
               end
            end
         end
         if (aug[i][i] == 0) return 1'b0;
         p = aug[i][i];
         for (int j = 0; j < 2*n; j++) aug[i][j] = q_div(aug[i][j], p);
         for (int k = 0; k < n; k++) begin
            if (k != i) begin
               f = aug[k][i];
               for (int j = 0; j < 2*n; j++) aug[k][j] = q_elim(aug[k][j], f, aug[i][j]);
            end
         end
      end
      return 1'b1;
   endfunction

   function automatic void absorb_element(req_word_type w);
      int n, total;
      rsp_word_type r;
      n = eff_order();
      total = n * n;
      if (load_cnt < total) begin
         aug[load_cnt / n][load_cnt % n] = w.element_value;
         load_cnt++;
         if (!w.last_element && load_cnt < total) return;
      end
      for (int idx = load_cnt; idx < total; idx++) aug[idx / n][idx % n] = 0;
      load_cnt = 0;
      if (!run_inverse(n)) begin
         r.inverse_value = '0; r.singular = 1'b1; r.last_result = 1'b1;
         inverse_q.push_back(r);
      end else begin
         for (int i = 0; i < total; i++) begin
            r.inverse_value = aug[i / n][n + i % n];
            r.singular = 1'b0;
            r.last_result = (i == total - 1);
            inverse_q.push_back(r);
         end
      end
   endfunction

   // sender: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) absorb_element(req_data);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (element_q.size() > 0) begin
               req_data <= element_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(0, 12);
                  gap_left = $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (csr_valid && csr_ready) begin
            order_reg = csr_data;
            csr_valid <= 1'b0;
         end
      end
   end

   // receiver: stall mode changes every so often
   int stall_mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (inverse_q.size() == 0) begin
               $display("%0t: unexpected word %h", $time, rsp_data);
               errors++;
            end else begin
               rsp_word_type e;
               e = inverse_q.pop_front();
               if (rsp_data.inverse_value !== e.inverse_value) begin
                  $display("%0t: inverse_value expected %h actual %h", $time,
                           e.inverse_value, rsp_data.inverse_value);
                  errors++;
               end
               if (rsp_data.singular !== e.singular) begin
                  $display("%0t: singular expected %b actual %b", $time,
                           e.singular, rsp_data.singular);
                  errors++;
               end
               if (rsp_data.last_result !== e.last_result) begin
                  $display("%0t: last_result expected %b actual %b", $time,
                           e.last_result, rsp_data.last_result);
                  errors++;
               end
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 300);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 15) == 0);
         endcase
      end
   end

   task automatic send(int v, bit last);
      req_word_type w;
      w.element_value = v;
      w.last_element = last;
      element_q.push_back(w);
      items++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (element_q.size() > 0 || req_valid || inverse_q.size() > 0) @(negedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_order(int v);
      wait_drained();
      @(posedge clock);
      csr_data <= CSR_W'(v);
      csr_valid <= 1'b1;
      @(negedge clock);
      while (csr_valid) @(negedge clock);
   endtask

   function automatic int small_val();
      return int'($urandom_range(0, 4*ONE)) - 2*ONE;
   endfunction

   // kinds: 0 well conditioned, 1 raw bits, 2 sparse, 3 zero diagonal, 4 zero row
   task automatic send_matrix(int n, int kind, int style);
      int total, cut, zrow, v;
      total = n * n;
      cut = $urandom_range(1, total);
      zrow = $urandom_range(0, n - 1);
      for (int i = 0; i < total; i++) begin
         case (kind)
            0: v = (i / n == i % n) ? ((4*ONE + int'($urandom_range(0, 4*ONE)))
                    * ($urandom_range(0, 1) ? 1 : -1)) : small_val();
            1: v = $urandom;
            2: v = ($urandom_range(0, 9) < 6) ? 0 : small_val();
            3: v = (i / n == i % n) ? 0 : small_val();
            default: v = (i / n == zrow) ? 0 : small_val();
         endcase
         case (style)
            1: begin  // early mark
               send(v, i == cut - 1);
               if (i == cut - 1) break;
            end
            2: send(v, 1'b0);  // full matrix, no mark
            3: send(v, $urandom_range(0, 15) == 0);  // stray marks
            default: send(v, i == total - 1);
         endcase
      end
   endtask

   initial begin
      int n, big_runs;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // size 1: unity, extremes, zero, tiny pivot
      write_order(1);
      send(ONE, 1'b1);
      send(32'sh80000000, 1'b1);
      send(32'sh7fffffff, 1'b0);
      send(0, 1'b1);
      send(1, 1'b1);
      // size 2: pivot swap, singular column, early mark, no mark
      write_order(2);
      send(0, 1'b0); send(ONE, 1'b0); send(ONE, 1'b0); send(0, 1'b1);
      send(0, 1'b0); send(ONE, 1'b0); send(0, 1'b0); send(2*ONE, 1'b1);
      send(3*ONE, 1'b0); send(ONE, 1'b1);
      send(ONE, 1'b0); send(2*ONE, 1'b0); send(-ONE, 1'b0); send(ONE, 1'b0);
      // size zero acts as one, oversize acts as the maximum
      write_order(0);
      send(-2*ONE, 1'b1);
      write_order(15);
      send(ONE, 1'b1);
      // partial load, then shrink: next element is dropped and starts the run
      write_order(3);
      for (int i = 0; i < 5; i++) send(small_val(), 1'b0);
      write_order(2);
      send(ONE, 1'b0);

      big_runs = 0;
      while (items < 400) begin
         case ($urandom_range(0, 9))
            0, 1, 2: n = 1;
            3, 4, 5: n = 2;
            6, 7: n = 3;
            8: n = $urandom_range(4, 6);
            default: n = (big_runs < 2) ? 8 : 7;
         endcase
         if (n == 8) big_runs++;
         write_order(n);
         for (int m = (n >= 7) ? 1 : $urandom_range(2, 5); m > 0; m--) begin
            send_matrix(n, $urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 4),
                        $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3));
            if ($urandom_range(0, 7) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #30000000;
      $display("FAILURE");
      $finish;
   end

endmodule

### sim.f
design/gjmi_pkg.sv
design/gjmi_ram.sv
design/gauss_jordan_matrix_inverse.sv
bench/tb_gauss_jordan_matrix_inverse.sv
